/* hw/rtl/csu_pkg.sv */
// Shared types, character codes and the per-byte step function of the comment stripper.
package csu_pkg;

  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_CLEAN = 2'd1,
    KIND_OPEN  = 2'd2
  } kind_e;

  typedef struct packed {
    logic in_comment;
    logic after_space;
    logic held_star;
    logic held_slash;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } result_t;

  // Up to three results caused by one item, slot 0 first.
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               cnt;
  } batch_t;

  typedef struct packed {
    state_t nxt;
    batch_t batch;
  } step_t;

  function automatic step_t csu_step_fn(state_t st, logic [7:0] b, logic last);
    step_t      r;
    logic       consumed;
    logic [1:0] n;
    r        = '0;
    r.nxt    = st;
    consumed = 1'b0;
    n        = 2'd0;

    // Resolve a held delimiter candidate against the new byte.
    if (st.held_star) begin
      r.nxt.held_star  = 1'b0;
      r.nxt.held_slash = 1'b0;
      if (b == ChSlash) begin
        r.nxt.in_comment = 1'b0;
        consumed         = 1'b1;
      end else if (!st.in_comment) begin
        r.batch.res[n] = '{data: ChStar, kind: KIND_CHAR};
        n = n + 2'd1;
        r.nxt.after_space = 1'b0;
      end
    end else if (st.held_slash) begin
      r.nxt.held_slash = 1'b0;
      if (b == ChStar) begin
        r.nxt.in_comment = 1'b1;
        consumed         = 1'b1;
      end else begin
        r.batch.res[n] = '{data: ChSlash, kind: KIND_CHAR};
        n = n + 2'd1;
        r.nxt.after_space = 1'b0;
      end
    end

    if (!consumed) begin
      if (b == ChStar) begin
        r.nxt.held_star = 1'b1;
      end else if (r.nxt.in_comment) begin
        r.nxt.held_star = r.nxt.held_star;
      end else if (b inside {ChSpace, [8'h09:8'h0D]}) begin
        if (!r.nxt.after_space) begin
          r.batch.res[n] = '{data: ChSpace, kind: KIND_CHAR};
          n = n + 2'd1;
          r.nxt.after_space = 1'b1;
        end
      end else if (b == ChSlash) begin
        r.nxt.held_slash = 1'b1;
      end else begin
        r.batch.res[n] = '{data: b, kind: KIND_CHAR};
        n = n + 2'd1;
        r.nxt.after_space = 1'b0;
      end
    end

    // End of stream: flush the held byte, report the end, restart.
    if (last) begin
      if (r.nxt.held_star) begin
        if (!r.nxt.in_comment) begin
          r.batch.res[n] = '{data: ChStar, kind: KIND_CHAR};
          n = n + 2'd1;
        end
      end else if (r.nxt.held_slash) begin
        r.batch.res[n] = '{data: ChSlash, kind: KIND_CHAR};
        n = n + 2'd1;
      end
      r.batch.res[n] = '{data: 8'h00, kind: (r.nxt.in_comment ? KIND_OPEN : KIND_CLEAN)};
      n = n + 2'd1;
      r.nxt = '0;
    end

    r.batch.cnt = n;
    return r;
  endfunction

endpackage

/* hw/rtl/csu_step.sv */
// Scanner state registers and the combinational step that turns one byte into results.
module csu_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      data_i,
  input  logic            last_i,
  output csu_pkg::batch_t batch_o
);
  import csu_pkg::*;

  state_t st_q;
  step_t  step;

  always_comb begin
    step = csu_step_fn(st_q, data_i, last_i);
  end

  assign batch_o = step.batch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= step.nxt;
    end
  end

endmodule

/* hw/rtl/csu_out_buf.sv */
// Register bank that plays out one item's results, one per cycle while ready_i.
module csu_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  csu_pkg::batch_t batch_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [7:0]      data_o,
  output logic [1:0]      kind_o,
  output logic            last_o
);
  import csu_pkg::*;

  result_t [MaxResults-1:0] res_q;
  logic [1:0] cnt_q, idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       drain_last;
  result_t    cur;

  assign cur        = res_q[idx_q];
  assign valid_o    = busy_q;
  assign data_o     = cur.data;
  assign kind_o     = cur.kind;
  assign last_o     = (idx_q == cnt_q - 2'd1);
  assign drain_last = busy_q && ready_i && last_o;
  assign free_o     = !busy_q || drain_last;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      // An item with no results leaves the bank free.
      busy_d = (batch_i.cnt != 2'd0);
      idx_d  = 2'd0;
    end else if (busy_q && ready_i) begin
      if (last_o) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= batch_i.res;
      cnt_q <= batch_i.cnt;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < cnt_q))
    else $error("result index beyond result count");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !ready_i) |=> (busy_q && $stable(idx_q)))
    else $error("stalled result moved");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || drain_last))
    else $error("result bank overwritten before drained");

endmodule

/* hw/rtl/comment_strip_space_collapse_unit.sv */
// Top level of the block comment stripper with whitespace collapse.
//
// Bytes enter on the s_axis channel, tlast marking the final byte of a stream.
// Results leave on the m_axis channel: tdata is the byte, tuser the kind
// (character, clean end, end inside an open comment), and tlast flags the last
// result caused by one input item. An item may cause zero to three results.
// Each accepted byte is held in the input register, is scanned against the
// comment and whitespace flags in a single pass, and its results are loaded
// into the result bank, which presents them on m_axis one after another.
// One item is taken per cycle while the receiver is ready and each item gives
// at most one result; an item with more results holds the result bank until
// the last of them has been taken.
// The input register refills in the same cycle that the bank drains, so a
// stalled receiver backs up through the bank into the input register and then
// drops s_axis_tready. Reset clears the scanner flags and empties both
// registers; the end of each stream also returns the flags to reset state.
module comment_strip_space_collapse_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [1:0] m_axis_tuser,  // [1:0] kind
  output logic       m_axis_tlast
);
  import csu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       bank_free;
  logic       proc_fire;
  logic       s_fire;
  batch_t     batch;

  assign proc_fire     = in_valid_q && bank_free;
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  csu_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (proc_fire),
    .data_i  (in_byte_q),
    .last_i  (in_last_q),
    .batch_o (batch)
  );

  csu_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (proc_fire),
    .batch_i (batch),
    .free_o  (bank_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .kind_o  (m_axis_tuser),
    .last_o  (m_axis_tlast)
  );

endmodule
